// ----- hdl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED = 3'd1;
   localparam logic [2:0] ERR_CONTROL   = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
   localparam logic [2:0] ERR_BAD_ESC   = 3'd4;

   // Decoder modes.
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;
   localparam logic [1:0] MODE_IDLE   = 2'd3;

   // Characters with a meaning of their own.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CTRL_MAX     = 8'h1F;

   localparam logic [20:0] SUPP_BASE = 21'h10000;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic [2:0] err;
   } item_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_type;

   // UTF-8 encoding of a code point of up to 21 bits; byte 0 goes out first.
   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.len      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r.len      = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.len      = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   // Hex digit value; bit 4 is set when the byte is a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes the body of a JSON string, one raw byte per transfer, into UTF-8
// bytes, an end item at the closing quote, or an error item.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   req      | in        | req_valid/req_stall  | in_byte, start_req, end_of_input
//   rsp      | out       | rsp_valid/rsp_stall  | out_byte, kind, error_code, last
//
// An input byte is decoded in the cycle it is taken; its results (zero to four)
// go out of a four-entry result register, one per cycle while rsp_stall is low,
// from the next cycle. A byte with one result or none is taken every cycle while
// rsp_stall is low; a byte with more results holds the input as the register
// drains one per cycle. A new byte is taken in the cycle the last result leaves.
// Reset clears the mode and the \u state and empties the result register.
// rsp_stall freezes the current result, and req_stall stays high while a run waits.
`default_nettype none

module json_string_unescape
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_start_req,
   input  wire logic       req_end_of_input,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_kind,
   output logic [2:0]      rsp_error_code,
   output logic            rsp_last
);

   logic [1:0]  mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] pcode_ff, pcode_in;
   logic        pvalid_ff, pvalid_in;

   item_type [3:0] buf_ff, buf_in;
   logic [1:0]     lastidx_ff, lastidx_in;
   logic [1:0]     idx_ff, idx_in;
   logic           busy_ff, busy_in;

   logic req_fire, rsp_fire, run_done;

   // Current state as seen by this byte, after a start clears it.
   logic [1:0]  mode_cur;
   logic [15:0] acc_cur, pcode_cur;
   logic [1:0]  cnt_cur;
   logic        pvalid_cur;

   logic [4:0]  hexd;
   logic [15:0] acc_next;
   logic        join_pair;
   logic [20:0] joined_cp;
   logic        use_enc;
   utf8_type    enc;
   logic        has_tail;
   item_type    tail;
   logic [2:0]  enc_len, n_items;

   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign run_done  = rsp_fire && (idx_ff == lastidx_ff);
   assign req_stall = busy_ff && !run_done;
   assign req_fire  = req_valid && !req_stall;

   assign mode_cur   = req_start_req ? MODE_NORMAL : mode_ff;
   assign acc_cur    = req_start_req ? 16'd0 : acc_ff;
   assign cnt_cur    = req_start_req ? 2'd0 : cnt_ff;
   assign pcode_cur  = req_start_req ? 16'd0 : pcode_ff;
   assign pvalid_cur = req_start_req ? 1'b0 : pvalid_ff;

   assign hexd      = hex_digit(req_in_byte);
   assign acc_next  = {acc_cur[11:0], hexd[3:0]};
   assign join_pair = pvalid_cur && (pcode_cur >= 16'hD800) && (pcode_cur <= 16'hDBFF)
                      && (acc_next >= 16'hDC00) && (acc_next <= 16'hDFFF);
   assign joined_cp = {1'b0, pcode_cur[9:0], acc_next[9:0]} + SUPP_BASE;

   always_comb begin
      mode_in   = mode_cur;
      acc_in    = acc_cur;
      cnt_in    = cnt_cur;
      pcode_in  = pcode_cur;
      pvalid_in = pvalid_cur;
      use_enc   = 1'b0;
      enc       = utf8_encode({5'd0, pcode_cur});
      has_tail  = 1'b0;
      tail      = '{data: 8'd0, kind: KIND_DATA, err: ERR_NONE};

      if (mode_cur == MODE_IDLE) begin
         // Nothing until the next start.
      end else if (req_end_of_input) begin
         has_tail  = 1'b1;
         tail      = '{data: 8'd0, kind: KIND_ERR,
                       err: (mode_cur == MODE_HEX) ? ERR_BAD_HEX : ERR_TRUNCATED};
         pvalid_in = 1'b0;
         mode_in   = MODE_IDLE;
      end else begin
         unique case (mode_cur)
            MODE_NORMAL: begin
               if (req_in_byte == CH_QUOTE) begin
                  use_enc   = pvalid_cur;
                  has_tail  = 1'b1;
                  tail      = '{data: 8'd0, kind: KIND_END, err: ERR_NONE};
                  pvalid_in = 1'b0;
                  mode_in   = MODE_IDLE;
               end else if (req_in_byte <= CTRL_MAX) begin
                  has_tail  = 1'b1;
                  tail      = '{data: 8'd0, kind: KIND_ERR, err: ERR_CONTROL};
                  pvalid_in = 1'b0;
                  mode_in   = MODE_IDLE;
               end else if (req_in_byte == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  use_enc   = pvalid_cur;
                  has_tail  = 1'b1;
                  tail      = '{data: req_in_byte, kind: KIND_DATA, err: ERR_NONE};
                  pvalid_in = 1'b0;
               end
            end
            MODE_ESC: begin
               use_enc   = pvalid_cur;
               has_tail  = 1'b1;
               pvalid_in = 1'b0;
               mode_in   = MODE_NORMAL;
               unique case (req_in_byte) inside
                  CH_LOWER_U: begin
                     use_enc   = 1'b0;
                     has_tail  = 1'b0;
                     pvalid_in = pvalid_cur;
                     mode_in   = MODE_HEX;
                     acc_in    = 16'd0;
                     cnt_in    = 2'd0;
                  end
                  CH_LOWER_B: tail.data = 8'h08;
                  CH_LOWER_F: tail.data = 8'h0C;
                  CH_LOWER_N: tail.data = 8'h0A;
                  CH_LOWER_R: tail.data = 8'h0D;
                  CH_LOWER_T: tail.data = 8'h09;
                  CH_QUOTE, CH_BACKSLASH, CH_SLASH: tail.data = req_in_byte;
                  default: begin
                     // Unknown escape letter: the pending value is dropped.
                     use_enc = 1'b0;
                     tail    = '{data: 8'd0, kind: KIND_ERR, err: ERR_BAD_ESC};
                     mode_in = MODE_IDLE;
                  end
               endcase
            end
            MODE_HEX: begin
               if (!hexd[4]) begin
                  has_tail  = 1'b1;
                  tail      = '{data: 8'd0, kind: KIND_ERR, err: ERR_BAD_HEX};
                  pvalid_in = 1'b0;
                  mode_in   = MODE_IDLE;
               end else begin
                  acc_in = acc_next;
                  if (cnt_cur == 2'd3) begin
                     cnt_in  = 2'd0;
                     mode_in = MODE_NORMAL;
                     if (join_pair) begin
                        use_enc   = 1'b1;
                        enc       = utf8_encode(joined_cp);
                        pvalid_in = 1'b0;
                     end else begin
                        // The old value goes out; the new one waits for what follows.
                        use_enc   = pvalid_cur;
                        pcode_in  = acc_next;
                        pvalid_in = 1'b1;
                     end
                  end else begin
                     cnt_in = cnt_cur + 2'd1;
                  end
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   assign enc_len = use_enc ? enc.len : 3'd0;
   assign n_items = enc_len + {2'd0, has_tail};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < enc_len) begin
            buf_in[i] = '{data: enc.bytes[i], kind: KIND_DATA, err: ERR_NONE};
         end else begin
            buf_in[i] = tail;
         end
      end
      lastidx_in = 2'(n_items - 3'd1);
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (run_done) begin
         busy_in = 1'b0;
      end else if (rsp_fire) begin
         idx_in = idx_ff + 2'd1;
      end
      // A byte taken as the last result leaves starts the next run right away.
      if (req_fire && n_items != 3'd0) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         acc_ff    <= 16'd0;
         cnt_ff    <= 2'd0;
         pcode_ff  <= 16'd0;
         pvalid_ff <= 1'b0;
         busy_ff   <= 1'b0;
         idx_ff    <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (req_fire) begin
            mode_ff   <= mode_in;
            acc_ff    <= acc_in;
            cnt_ff    <= cnt_in;
            pcode_ff  <= pcode_in;
            pvalid_ff <= pvalid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && n_items != 3'd0) begin
         buf_ff     <= buf_in;
         lastidx_ff <= lastidx_in;
      end
   end

   assign rsp_valid      = busy_ff;
   assign rsp_out_byte   = buf_ff[idx_ff].data;
   assign rsp_kind       = buf_ff[idx_ff].kind;
   assign rsp_error_code = buf_ff[idx_ff].err;
   assign rsp_last       = (idx_ff == lastidx_ff);

   // The input is held back only while a run of results is waiting.
   a_stall_needs_run: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall high with no result waiting");

   // End and error items always close the run of their byte.
   a_end_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_DATA) |-> rsp_last)
      else $error("end or error item not marked last");

   // A run that is not finished keeps going in the next cycle.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_last) |=> rsp_valid)
      else $error("result run broken off before its last item");

   // Error items carry a real code, other items none.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERR) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not match result kind");

endmodule

`default_nettype wire
